>>> hw/rtl/intel_hex_record_parser_defines.svh
// Assertion macros shared by the Intel HEX record parser RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef INTEL_HEX_RECORD_PARSER_DEFINES_SVH
`define INTEL_HEX_RECORD_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define IHEX_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define IHEX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/ihex_pkg.sv
// Shared types and constants for the Intel HEX record parser.
// Depends on nothing; used by every module of the parser.
package ihex_pkg;

    localparam int IHEX_QUEUE_DEPTH = 4;

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_LF    = 8'h0A;

    localparam logic [7:0] REC_DATA         = 8'h00;
    localparam logic [7:0] REC_EXT_LINEAR   = 8'h04;
    localparam logic [7:0] REC_START_LINEAR = 8'h05;

    localparam logic [2:0] KIND_DATA       = 3'd0;
    localparam logic [2:0] KIND_BASE       = 3'd1;
    localparam logic [2:0] KIND_START      = 3'd2;
    localparam logic [2:0] KIND_CHECKED    = 3'd3;
    localparam logic [2:0] KIND_DONE       = 3'd4;
    localparam logic [2:0] KIND_BAD_FORMAT = 3'd5;
    localparam logic [2:0] KIND_BAD_TYPE   = 3'd6;

    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_input;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] address;
        logic [7:0]  data_byte;
        logic        checksum_ok;
        logic        start_valid;
    } t_out_item;

    // Byte-level operations handed from the front end to the back end.
    typedef enum logic [3:0] {
        OP_COUNT      = 4'd0,
        OP_ADDR       = 4'd1,
        OP_TYPE       = 4'd2,
        OP_DATA       = 4'd3,
        OP_BASE       = 4'd4,
        OP_BASE_LAST  = 4'd5,
        OP_START      = 4'd6,
        OP_START_LAST = 4'd7,
        OP_CSUM       = 4'd8,
        OP_DONE       = 4'd9,
        OP_BAD_FORMAT = 4'd10,
        OP_BAD_TYPE   = 4'd11
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] value;
        logic [7:0] index;
    } t_cmd;

endpackage

>>> hw/rtl/ihex_front.sv
// Character front end: colon and line-feed handling, hex digit pairing and
// record field sequencing. Depends on ihex_pkg; feeds ihex_queue.
module ihex_front
    import ihex_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in_data,
    input  logic     i_queue_full,
    output logic     o_push,
    output t_cmd     o_push_cmd,
    output logic     o_done
);

    typedef enum logic [9:0] {
        PH_WAIT  = 10'b00_0000_0001,
        PH_COUNT = 10'b00_0000_0010,
        PH_ADDR  = 10'b00_0000_0100,
        PH_TYPE  = 10'b00_0000_1000,
        PH_DATA  = 10'b00_0001_0000,
        PH_BASE  = 10'b00_0010_0000,
        PH_START = 10'b00_0100_0000,
        PH_CSUM  = 10'b00_1000_0000,
        PH_SKIP  = 10'b01_0000_0000,
        PH_DONE  = 10'b10_0000_0000
    } t_phase;

    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [3:0] n;
        n = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            n = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            n = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            n = 4'(c - 8'h37);
        end
        return n;
    endfunction

    t_phase     r_phase, n_phase;
    logic       r_digit_hi, n_digit_hi;
    logic [3:0] r_hi_nib, n_hi_nib;
    logic [7:0] r_bytes_left, n_bytes_left;
    logic [7:0] r_idx, n_idx;

    logic       w_fire;
    logic [7:0] w_byte;
    logic [7:0] w_idx_inc;

    assign o_in_ready = !i_queue_full;
    assign w_fire     = i_in_valid && o_in_ready;
    assign w_byte     = {r_hi_nib, nibble_of(i_in_data.char_in)};
    assign w_idx_inc  = r_idx + 8'd1;
    assign o_done     = (r_phase == PH_DONE);

    always_comb begin
        n_phase          = r_phase;
        n_digit_hi       = r_digit_hi;
        n_hi_nib         = r_hi_nib;
        n_bytes_left     = r_bytes_left;
        n_idx            = r_idx;
        o_push           = 1'b0;
        o_push_cmd.op    = OP_COUNT;
        o_push_cmd.value = w_byte;
        o_push_cmd.index = r_idx;
        if (w_fire && r_phase != PH_DONE) begin
            if (i_in_data.end_of_input) begin
                o_push        = 1'b1;
                o_push_cmd.op = OP_BAD_FORMAT;
                n_phase       = PH_DONE;
            end else begin
                case (r_phase)
                    PH_WAIT: begin
                        if (i_in_data.char_in != CHAR_COLON) begin
                            o_push        = 1'b1;
                            o_push_cmd.op = OP_BAD_FORMAT;
                            n_phase       = PH_DONE;
                        end else begin
                            n_digit_hi = 1'b0;
                            n_phase    = PH_COUNT;
                        end
                    end
                    PH_SKIP: begin
                        if (i_in_data.char_in == CHAR_LF) begin
                            n_phase = PH_WAIT;
                        end
                    end
                    default: begin
                        if (!r_digit_hi) begin
                            n_hi_nib   = nibble_of(i_in_data.char_in);
                            n_digit_hi = 1'b1;
                        end else begin
                            n_digit_hi = 1'b0;
                            o_push     = 1'b1;
                            case (r_phase)
                                PH_COUNT: begin
                                    if (w_byte == 8'd0) begin
                                        o_push_cmd.op = OP_DONE;
                                        n_phase       = PH_DONE;
                                    end else begin
                                        o_push_cmd.op = OP_COUNT;
                                        n_bytes_left  = w_byte;
                                        n_idx         = 8'd0;
                                        n_phase       = PH_ADDR;
                                    end
                                end
                                PH_ADDR: begin
                                    o_push_cmd.op = OP_ADDR;
                                    if (r_idx == 8'd1) begin
                                        n_idx   = 8'd0;
                                        n_phase = PH_TYPE;
                                    end else begin
                                        n_idx = w_idx_inc;
                                    end
                                end
                                PH_TYPE: begin
                                    o_push_cmd.op = OP_TYPE;
                                    n_idx         = 8'd0;
                                    if (w_byte == REC_DATA) begin
                                        n_phase = PH_DATA;
                                    end else if (w_byte == REC_EXT_LINEAR) begin
                                        n_phase = PH_BASE;
                                    end else if (w_byte == REC_START_LINEAR) begin
                                        n_phase = PH_START;
                                    end else begin
                                        o_push_cmd.op = OP_BAD_TYPE;
                                        n_phase       = PH_DONE;
                                    end
                                end
                                PH_DATA: begin
                                    o_push_cmd.op = OP_DATA;
                                    n_idx         = w_idx_inc;
                                    if (w_idx_inc == r_bytes_left) begin
                                        n_phase = PH_CSUM;
                                    end
                                end
                                PH_BASE: begin
                                    n_idx = w_idx_inc;
                                    if (r_idx == 8'd1) begin
                                        o_push_cmd.op = OP_BASE_LAST;
                                        n_phase       = PH_CSUM;
                                    end else begin
                                        o_push_cmd.op = OP_BASE;
                                    end
                                end
                                PH_START: begin
                                    n_idx = w_idx_inc;
                                    if (r_idx == 8'd3) begin
                                        o_push_cmd.op = OP_START_LAST;
                                        n_phase       = PH_CSUM;
                                    end else begin
                                        o_push_cmd.op = OP_START;
                                    end
                                end
                                default: begin
                                    o_push_cmd.op = OP_CSUM;
                                    n_phase       = PH_SKIP;
                                end
                            endcase
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_WAIT;
            r_digit_hi   <= 1'b0;
            r_bytes_left <= 8'd0;
            r_idx        <= 8'd0;
        end else begin
            r_phase      <= n_phase;
            r_digit_hi   <= n_digit_hi;
            r_bytes_left <= n_bytes_left;
            r_idx        <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hi_nib <= n_hi_nib;
    end

endmodule

>>> hw/rtl/ihex_queue.sv
// Small register queue of byte operations between front and back ends.
// Depends on ihex_pkg for the entry type.
module ihex_queue
    import ihex_pkg::*;
#(
    parameter int DEPTH = IHEX_QUEUE_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  t_cmd                         i_push_cmd,
    output logic                         o_full,
    output logic                         o_pop_valid,
    output t_cmd                         o_pop_cmd,
    input  logic                         i_pop,
    output logic [$clog2(DEPTH+1)-1:0]   o_level
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LVL_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [LVL_W-1:0] r_level, n_level;
    logic             w_push, w_pop;

    assign o_full      = (r_level == LVL_W'(DEPTH));
    assign o_pop_valid = (r_level != '0);
    assign o_pop_cmd   = r_mem[r_rd];
    assign o_level     = r_level;
    assign w_push      = i_push && !o_full;
    assign w_pop       = i_pop && o_pop_valid;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_level = r_level;
        if (w_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (w_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_level = r_level + 1'b1;
        end else if (w_pop && !w_push) begin
            n_level = r_level - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_level <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_push_cmd;
        end
    end

endmodule

>>> hw/rtl/ihex_back.sv
// Back end: checksum, address and start state, and the output register.
// Depends on ihex_pkg; drains ihex_queue.
module ihex_back
    import ihex_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    input  t_cmd      i_cmd,
    output logic      o_cmd_pop,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    logic [7:0]  r_sum, n_sum;
    logic [15:0] r_offset, n_offset;
    logic [15:0] r_base, n_base;
    logic [31:0] r_start, n_start;
    logic        r_start_seen, n_start_seen;
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out, n_out;
    logic        w_has_result;
    logic [7:0]  w_sum_inc;
    logic [31:0] w_data_addr;

    // A new operation is taken whenever the output register is free or draining.
    assign o_cmd_pop   = i_cmd_valid && (!r_out_valid || i_out_ready);
    assign w_sum_inc   = r_sum + i_cmd.value;
    assign w_data_addr = {r_base, 16'h0000} + {16'h0000, r_offset} + {24'h0, i_cmd.index};
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_sum        = r_sum;
        n_offset     = r_offset;
        n_base       = r_base;
        n_start      = r_start;
        n_start_seen = r_start_seen;
        w_has_result = 1'b0;
        n_out        = '0;
        case (i_cmd.op)
            OP_COUNT: begin
                n_sum = i_cmd.value;
            end
            OP_ADDR: begin
                n_sum    = w_sum_inc;
                n_offset = {r_offset[7:0], i_cmd.value};
            end
            OP_TYPE: begin
                n_sum = w_sum_inc;
            end
            OP_DATA: begin
                n_sum           = w_sum_inc;
                w_has_result    = 1'b1;
                n_out.kind      = KIND_DATA;
                n_out.address   = w_data_addr;
                n_out.data_byte = i_cmd.value;
            end
            OP_BASE: begin
                n_sum  = w_sum_inc;
                n_base = {r_base[7:0], i_cmd.value};
            end
            OP_BASE_LAST: begin
                n_sum         = w_sum_inc;
                n_base        = {r_base[7:0], i_cmd.value};
                w_has_result  = 1'b1;
                n_out.kind    = KIND_BASE;
                n_out.address = {r_base[7:0], i_cmd.value, 16'h0000};
            end
            OP_START: begin
                n_sum   = w_sum_inc;
                n_start = {r_start[23:0], i_cmd.value};
            end
            OP_START_LAST: begin
                n_sum         = w_sum_inc;
                n_start       = {r_start[23:0], i_cmd.value};
                n_start_seen  = 1'b1;
                w_has_result  = 1'b1;
                n_out.kind    = KIND_START;
                n_out.address = {r_start[23:0], i_cmd.value};
            end
            OP_CSUM: begin
                w_has_result      = 1'b1;
                n_out.kind        = KIND_CHECKED;
                n_out.data_byte   = i_cmd.value;
                n_out.checksum_ok = (w_sum_inc == 8'd0);
            end
            OP_DONE: begin
                w_has_result      = 1'b1;
                n_out.kind        = KIND_DONE;
                n_out.start_valid = r_start_seen;
            end
            OP_BAD_FORMAT: begin
                w_has_result = 1'b1;
                n_out.kind   = KIND_BAD_FORMAT;
            end
            OP_BAD_TYPE: begin
                w_has_result = 1'b1;
                n_out.kind   = KIND_BAD_TYPE;
            end
            default: begin
                w_has_result = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd_pop) begin
            n_out_valid = w_has_result;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum        <= 8'd0;
            r_offset     <= 16'd0;
            r_base       <= 16'd0;
            r_start      <= 32'd0;
            r_start_seen <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (o_cmd_pop) begin
                r_sum        <= n_sum;
                r_offset     <= n_offset;
                r_base       <= n_base;
                r_start      <= n_start;
                r_start_seen <= n_start_seen;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop && w_has_result) begin
            r_out <= n_out;
        end
    end

endmodule

>>> hw/rtl/intel_hex_record_parser.sv
// Channel   Direction  Payload      Handshake
// in        input      t_in_item    i_in_valid / o_in_ready
// out       output     t_out_item   o_out_valid / i_out_ready
//
// One character is taken every cycle while the operation queue has room.
// A result is pushed by the front end into the queue as the character that
// completes its byte is taken, and the back end moves it into the output
// register. A stalled output fills the queue of QUEUE_DEPTH entries
// before input is held off. Reset is synchronous and needs no clearing pass.
// Top level of the Intel HEX record parser; depends on ihex_pkg, ihex_front,
// ihex_queue, ihex_back and the assertion macro header.
`include "intel_hex_record_parser_defines.svh"

module intel_hex_record_parser
    import ihex_pkg::*;
#(
    parameter int QUEUE_DEPTH = IHEX_QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

    logic             w_push;
    t_cmd             w_push_cmd;
    logic             w_full;
    logic             w_done;
    logic             w_pop_valid;
    t_cmd             w_pop_cmd;
    logic             w_pop;
    logic [LVL_W-1:0] w_level;
    logic             w_terminal;

    ihex_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_queue_full (w_full),
        .o_push       (w_push),
        .o_push_cmd   (w_push_cmd),
        .o_done       (w_done)
    );

    ihex_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_cmd  (w_push_cmd),
        .o_full      (w_full),
        .o_pop_valid (w_pop_valid),
        .o_pop_cmd   (w_pop_cmd),
        .i_pop       (w_pop),
        .o_level     (w_level)
    );

    ihex_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_pop_valid),
        .i_cmd       (w_pop_cmd),
        .o_cmd_pop   (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // The parse ends with a done, bad format or bad type transaction.
    assign w_terminal = (o_out_data.kind == KIND_DONE) ||
                        (o_out_data.kind == KIND_BAD_FORMAT) ||
                        (o_out_data.kind == KIND_BAD_TYPE);

    `IHEX_ASSERT_NEXT(a_quiet_after_end, i_clk, i_rst_n, o_out_valid && i_out_ready && w_terminal, !o_out_valid, "result after the parse had ended")
    `IHEX_ASSERT_NEXT(a_no_late_result, i_clk, i_rst_n, w_done && (w_level == '0) && !o_out_valid, !o_out_valid, "result appeared from an empty queue after the end")
    `IHEX_ASSERT_NOW(a_queue_bound, i_clk, i_rst_n, 1'b1, w_level <= LVL_W'(QUEUE_DEPTH), "queue level beyond its depth")

endmodule

>>> sim/testbench.sv
// Self-checking testbench for the Intel HEX record parser: streams record text, predicts
// every result in step with the accepted characters and checks each output transaction.
// Depends on ihex_pkg and intel_hex_record_parser.
module testbench;
    import ihex_pkg::*;

    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_UP_A = 8'h41;
    localparam logic [7:0] CH_UP_F = 8'h46;
    localparam logic [7:0] CH_LO_A = 8'h61;
    localparam logic [7:0] CH_LO_F = 8'h66;
    localparam logic [7:0] CH_CR   = 8'h0D;

    localparam logic [7:0] REC_EOF = 8'h01;

    localparam int QUIET_LIMIT = 2000;
    localparam int LONG_HOLD   = 120;
    localparam int TAIL_CYCLES = 20;

    typedef enum logic [3:0] {
        PH_COLON, PH_COUNT, PH_ADDR, PH_TYPE, PH_DATA, PH_BASE, PH_START, PH_CSUM, PH_SKIP
    } t_phase;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_data;

    // Predicted parser state.
    t_phase      rx_phase = PH_COLON;
    logic        second_digit = 1'b0;
    logic [7:0]  partial_byte = '0;
    logic [7:0]  body_len = '0;
    logic [15:0] rec_offset = '0;
    logic [7:0]  byte_idx = '0;
    logic [15:0] upper_base = '0;
    logic [31:0] entry_addr = '0;
    logic        entry_seen = 1'b0;
    logic [7:0]  rec_sum = '0;
    logic        parse_done = 1'b0;

    t_out_item   awaited_results[$];
    int          error_count = 0;
    int          chars_sent = 0;
    int          quiet_cycles = 0;
    bit          no_idle = 1'b0;
    int unsigned hold_requests = 0;
    int unsigned holds_served = 0;
    int          rx_wait = 0;

    intel_hex_record_parser i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int idle_len();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Returns {is_hex_digit, value}.
    function automatic logic [4:0] decode_digit(input logic [7:0] c);
        if (c >= CH_0 && c <= CH_9) return {1'b1, 4'(c - CH_0)};
        if (c >= CH_LO_A && c <= CH_LO_F) return {1'b1, 4'(c - CH_LO_A + 8'd10)};
        if (c >= CH_UP_A && c <= CH_UP_F) return {1'b1, 4'(c - CH_UP_A + 8'd10)};
        return 5'd0;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit lower);
        if (nib < 4'd10) return CH_0 + 8'(nib);
        return (lower ? CH_LO_A : CH_UP_A) + 8'(nib) - 8'd10;
    endfunction

    function automatic logic [7:0] noise_char(input bit non_hex);
        logic [7:0] c;
        logic [4:0] d;
        do begin
            c = 8'($urandom_range(0, 255));
            d = decode_digit(c);
        end while (c == CHAR_LF || (non_hex && d[4]));
        return c;
    endfunction

    function automatic logic [7:0] edgy_byte();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch: %s got %h, expected %h", what, got, want);
        error_count++;
    endtask

    task automatic await_result(input logic [2:0] kind, input logic [31:0] addr,
                                input logic [7:0] db, input logic ok, input logic sv);
        t_out_item r;
        r.kind        = kind;
        r.address     = addr;
        r.data_byte   = db;
        r.checksum_ok = ok;
        r.start_valid = sv;
        awaited_results.push_back(r);
    endtask

    // Advances the predicted parser by one accepted character.
    task automatic track_char(input t_in_item item);
        logic [4:0]  d;
        logic [7:0]  b;
        logic [31:0] a;
        if (parse_done) return;
        if (item.end_of_input) begin
            parse_done = 1'b1;
            await_result(KIND_BAD_FORMAT, '0, '0, 1'b0, 1'b0);
            return;
        end
        if (rx_phase == PH_COLON) begin
            if (item.char_in != CHAR_COLON) begin
                parse_done = 1'b1;
                await_result(KIND_BAD_FORMAT, '0, '0, 1'b0, 1'b0);
            end else begin
                rec_sum      = '0;
                second_digit = 1'b0;
                partial_byte = '0;
                rx_phase     = PH_COUNT;
            end
            return;
        end
        if (rx_phase == PH_SKIP) begin
            if (item.char_in == CHAR_LF) rx_phase = PH_COLON;
            return;
        end
        // Anything that is not a hex digit reads as zero inside a record.
        d = decode_digit(item.char_in);
        if (!second_digit) begin
            partial_byte = {d[3:0], 4'h0};
            second_digit = 1'b1;
            return;
        end
        b = partial_byte | {4'h0, d[3:0]};
        partial_byte = b;
        second_digit = 1'b0;
        case (rx_phase)
            PH_COUNT: begin
                rec_sum += b;
                if (b == 8'h00) begin
                    parse_done = 1'b1;
                    await_result(KIND_DONE, '0, '0, 1'b0, entry_seen);
                end else begin
                    body_len = b;
                    byte_idx = '0;
                    rx_phase = PH_ADDR;
                end
            end
            PH_ADDR: begin
                rec_sum += b;
                rec_offset = {rec_offset[7:0], b};
                byte_idx++;
                if (byte_idx >= 8'd2) begin
                    byte_idx = '0;
                    rx_phase = PH_TYPE;
                end
            end
            PH_TYPE: begin
                rec_sum += b;
                byte_idx = '0;
                if (b == REC_DATA) rx_phase = PH_DATA;
                else if (b == REC_EXT_LINEAR) rx_phase = PH_BASE;
                else if (b == REC_START_LINEAR) rx_phase = PH_START;
                else begin
                    parse_done = 1'b1;
                    await_result(KIND_BAD_TYPE, '0, '0, 1'b0, 1'b0);
                end
            end
            PH_DATA: begin
                rec_sum += b;
                a = {upper_base, 16'h0000} + 32'(rec_offset) + 32'(byte_idx);
                byte_idx++;
                if (byte_idx >= body_len) rx_phase = PH_CSUM;
                await_result(KIND_DATA, a, b, 1'b0, 1'b0);
            end
            PH_BASE: begin
                rec_sum += b;
                upper_base = {upper_base[7:0], b};
                byte_idx++;
                if (byte_idx >= 8'd2) begin
                    rx_phase = PH_CSUM;
                    await_result(KIND_BASE, {upper_base, 16'h0000}, '0, 1'b0, 1'b0);
                end
            end
            PH_START: begin
                rec_sum += b;
                entry_addr = {entry_addr[23:0], b};
                byte_idx++;
                if (byte_idx >= 8'd4) begin
                    entry_seen = 1'b1;
                    rx_phase   = PH_CSUM;
                    await_result(KIND_START, entry_addr, '0, 1'b0, 1'b0);
                end
            end
            PH_CSUM: begin
                rx_phase = PH_SKIP;
                await_result(KIND_CHECKED, '0, b, 8'(rec_sum + b) == 8'h00, 1'b0);
            end
            default: rx_phase = PH_SKIP;
        endcase
    endtask

    // Offers one character and returns once the transaction has been accepted.
    task automatic send_char(input logic [7:0] c, input logic eoi);
        t_in_item item;
        int gap;
        item = '{char_in: c, end_of_input: eoi};
        gap  = idle_len();
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_ready !== 1'b1) @(posedge clk);
        track_char(item);
        chars_sent++;
    endtask

    task automatic stop_sending();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic send_byte(input logic [7:0] b, input bit lower, input int mangle_pct);
        logic [7:0] hi;
        logic [7:0] lo;
        hi = hex_char(b[7:4], lower);
        lo = hex_char(b[3:0], lower);
        if ($urandom_range(0, 99) < mangle_pct) hi = noise_char(1'b1);
        if ($urandom_range(0, 99) < mangle_pct) lo = noise_char(1'b1);
        send_char(hi, 1'b0);
        send_char(lo, 1'b0);
    endtask

    // Only body and checksum digits are ever mangled, so the record framing stays intact.
    task automatic send_record(input logic [7:0] count, input logic [15:0] offset,
                               input logic [7:0] rtype, input logic [7:0] body[$],
                               input bit bad_sum, input int mangle_pct);
        logic [7:0] sum;
        bit lower;
        int tail;
        lower = 1'($urandom_range(0, 1));
        sum = count + offset[15:8] + offset[7:0] + rtype;
        foreach (body[i]) sum += body[i];
        sum = 8'(~sum + 8'd1);
        if (bad_sum) sum ^= 8'($urandom_range(1, 255));
        send_char(CHAR_COLON, 1'b0);
        send_byte(count, lower, 0);
        send_byte(offset[15:8], lower, 0);
        send_byte(offset[7:0], lower, 0);
        send_byte(rtype, lower, 0);
        foreach (body[i]) send_byte(body[i], lower, mangle_pct);
        send_byte(sum, lower, mangle_pct);
        tail = $urandom_range(0, 3);
        if (tail == 1) send_char(CH_CR, 1'b0);
        if (tail == 2) repeat ($urandom_range(1, 6)) send_char(noise_char(1'b0), 1'b0);
        send_char(CHAR_LF, 1'b0);
    endtask

    task automatic test_directed_records();
        logic [7:0] body[$];
        // Top base value; the count byte of a base record does not set its length.
        body = '{8'hFF, 8'hFF};
        send_record(8'hFF, 16'h0000, REC_EXT_LINEAR, body, 1'b0, 0);
        // The second byte lands past the top of the address space and wraps to zero.
        body = '{8'h00, 8'hFF};
        send_record(8'h02, 16'hFFFF, REC_DATA, body, 1'b0, 0);
    endtask

    task automatic test_random_records(input int upto);
        logic [7:0]  body[$];
        logic [15:0] offs;
        logic [7:0]  count;
        int pick;
        int len;
        int n;
        n = 0;
        while (chars_sent < upto) begin
            no_idle = ($urandom_range(0, 9) == 0);
            pick = (n == 0) ? 95 : $urandom_range(0, 99);
            offs = ($urandom_range(0, 9) == 0) ? 16'hFFF8 : 16'($urandom);
            body = {};
            if (pick < 74) begin
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 48)
                                                   : $urandom_range(1, 16);
                repeat (len) body.push_back(edgy_byte());
                send_record(8'(len), offs, REC_DATA, body, $urandom_range(0, 9) == 0, 3);
            end else begin
                len = (pick < 87) ? 2 : 4;
                repeat (len) body.push_back(edgy_byte());
                count = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255)) : 8'(len);
                send_record(count, offs, (pick < 87) ? REC_EXT_LINEAR : REC_START_LINEAR,
                            body, $urandom_range(0, 9) == 0, 3);
            end
            n++;
        end
        no_idle = 1'b0;
    endtask

    // The receiver holds off for a long stretch while a long data record keeps coming.
    task automatic test_output_stall();
        logic [7:0] body[$];
        repeat (24) body.push_back(8'($urandom));
        hold_requests++;
        no_idle = 1'b1;
        send_record(8'd24, 16'($urandom), REC_DATA, body, 1'b0, 0);
        no_idle = 1'b0;
    endtask

    task automatic test_drain_pause();
        logic [7:0] body[$];
        repeat (6) body.push_back(8'($urandom));
        send_record(8'd6, 16'($urandom), REC_DATA, body, 1'b0, 0);
        stop_sending();
        while (awaited_results.size() != 0) @(posedge clk);
    endtask

    // Exactly one way of ending the parse per run; everything afterwards is ignored.
    task automatic test_termination();
        logic [7:0] body[$];
        logic [7:0] rtype;
        logic [7:0] c;
        int n;
        case ($urandom_range(0, 3))
            0: send_record(8'h00, 16'h0000, REC_EOF, body, 1'b0, 0);
            1: begin
                do rtype = 8'($urandom_range(1, 255));
                while (rtype == REC_EXT_LINEAR || rtype == REC_START_LINEAR);
                body = '{8'($urandom), 8'($urandom)};
                send_record(8'h02, 16'($urandom), rtype, body, 1'b0, 0);
            end
            2: begin
                do c = 8'($urandom_range(0, 255));
                while (c == CHAR_COLON);
                send_char(c, 1'b0);
            end
            default: begin
                n = $urandom_range(0, 8);
                if (n > 0) begin
                    send_char(CHAR_COLON, 1'b0);
                    repeat (n - 1) send_char(hex_char(4'($urandom), 1'b0), 1'b0);
                end
                send_char(8'($urandom), 1'b1);
            end
        endcase
        repeat (12) send_char(8'($urandom), 1'($urandom));
    endtask

    // Receiver: random back-pressure, plus one long hold whenever the test asks for it.
    always @(negedge clk) begin : receiver
        int gap;
        if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            rx_wait = LONG_HOLD;
            out_ready <= 1'b0;
        end else if (rx_wait > 0) begin
            rx_wait--;
            out_ready <= 1'b0;
        end else begin
            gap = idle_len();
            if (gap > 0) begin
                rx_wait = gap - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin : check_results
        t_out_item want;
        if (rst_n && out_valid === 1'b1 && out_ready) begin
            if (awaited_results.size() == 0) begin
                report_mismatch("result with nothing awaited, kind", 32'(out_data.kind), '0);
            end else begin
                want = awaited_results.pop_front();
                if (out_data.kind !== want.kind)
                    report_mismatch("kind", 32'(out_data.kind), 32'(want.kind));
                if (out_data.address !== want.address)
                    report_mismatch("address", out_data.address, want.address);
                if (out_data.data_byte !== want.data_byte)
                    report_mismatch("data_byte", 32'(out_data.data_byte), 32'(want.data_byte));
                if (out_data.checksum_ok !== want.checksum_ok)
                    report_mismatch("checksum_ok", 32'(out_data.checksum_ok),
                                    32'(want.checksum_ok));
                if (out_data.start_valid !== want.start_valid)
                    report_mismatch("start_valid", 32'(out_data.start_valid),
                                    32'(want.start_valid));
            end
        end
    end

    // A transaction on either channel restarts the count.
    always @(posedge clk) begin
        if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("testbench: errors");
                $finish;
            end
        end
    end

    initial begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed_records();
        test_random_records(200);
        test_output_stall();
        test_drain_pause();
        test_random_records(420);
        test_termination();
        stop_sending();
        while (awaited_results.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
